@@ rtl/bwcr_pkg.sv @@
// Shared types and constants for the bar width code reader.
`default_nettype none
package bwcr_pkg;

  localparam int CODE_BITS = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MIN_LIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_MIN_DARK = 2'd2;

  localparam logic [7:0] WINDOW_SIZE_RST = 8'd100;
  localparam logic [7:0] WHITE_MIN_LIGHT_RST = 8'd90;
  localparam logic [7:0] BLACK_MIN_DARK_RST = 8'd80;

  typedef struct packed {
    logic [7:0] dark_count;
  } in_data_t;

  typedef struct packed {
    logic [7:0] white_width;
    logic [7:0] black_width;
    logic       bit_value;
    logic [2:0] code_value;
    logic       code_done;
  } out_data_t;

endpackage
`default_nettype wire

@@ rtl/bwcr_stream_if.sv @@
// Valid/ready stream interface that carries one beat of a payload type.
`default_nettype none
interface bwcr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/bar_width_code_reader_core.sv @@
// Top level of the bar width code reader: window classifier, run timer and code assembler.
// The block takes one sampling window per clock cycle and holds that rate for as long as
// the result side keeps up. A window beat is captured in an input register; the classifier,
// the run state machine and the code assembler then act on it and load the result register,
// which drives the output stream. Only windows that end a black run produce a result; the
// input stage stalls only while a result waits untaken in the result register and the window
// in hand would produce another.
`default_nettype none
module bar_width_code_reader_core
  import bwcr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bwcr_stream_if.sink                in_beat,
  bwcr_stream_if.source              out_beat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_WHITE,
    PH_BLACK
  } phase_t;

  localparam logic [1:0] LAST_POS = 2'(CODE_BITS - 1);

  logic [7:0] window_size_r;
  logic [7:0] white_min_light_r;
  logic [7:0] black_min_dark_r;

  logic       in_valid_r;
  logic [7:0] dark_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] white_run_r, white_run_nxt;
  logic [7:0] black_run_r, black_run_nxt;
  logic [1:0] bit_pos_r, bit_pos_nxt;
  logic [2:0] code_bits_r, code_bits_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r, out_data_nxt;

  logic [7:0] dark_clip;
  logic [7:0] light;
  logic       is_black;
  logic       is_white;
  logic       emit;
  logic       out_free;
  logic       stage_go;
  logic       bit_val;
  logic [1:0] shift;
  logic [2:0] code_set;
  logic       done;

  always_comb begin
    dark_clip = (dark_r > window_size_r) ? window_size_r : dark_r;
    light     = window_size_r - dark_clip;
    is_black  = dark_clip > black_min_dark_r;
    is_white  = light > white_min_light_r;
    emit      = (phase_r == PH_BLACK) && !is_black;
    out_free  = !out_valid_r || out_beat.ready;
    stage_go  = in_valid_r && (!emit || out_free);
    bit_val   = black_run_r > white_run_r;
    shift     = LAST_POS - bit_pos_r;
    code_set  = code_bits_r | (bit_val ? (3'b001 << shift) : 3'b000);
    done      = (bit_pos_r >= LAST_POS);
  end

  assign in_beat.ready  = !in_valid_r || stage_go;
  assign out_beat.valid = out_valid_r;
  assign out_beat.data  = out_data_r;

  always_comb begin
    phase_nxt     = phase_r;
    white_run_nxt = white_run_r;
    black_run_nxt = black_run_r;
    bit_pos_nxt   = bit_pos_r;
    code_bits_nxt = code_bits_r;
    out_valid_nxt = out_valid_r && !out_beat.ready;
    out_data_nxt  = out_data_r;
    if (stage_go) begin
      case (phase_r)
        PH_IDLE: begin
          if (is_black) phase_nxt = PH_START;
        end
        PH_START: begin
          if (!is_black) begin
            phase_nxt     = PH_WHITE;
            white_run_nxt = 8'd0;
          end
        end
        PH_WHITE: begin
          if (is_white) begin
            white_run_nxt = (white_run_r == 8'hFF) ? white_run_r : white_run_r + 8'd1;
          end else begin
            phase_nxt     = PH_BLACK;
            black_run_nxt = 8'd0;
          end
        end
        PH_BLACK: begin
          if (is_black) begin
            black_run_nxt = (black_run_r == 8'hFF) ? black_run_r : black_run_r + 8'd1;
          end else begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.white_width = white_run_r;
            out_data_nxt.black_width = black_run_r;
            out_data_nxt.bit_value   = bit_val;
            out_data_nxt.code_value  = code_set;
            out_data_nxt.code_done   = done;
            if (done) begin
              phase_nxt     = PH_IDLE;
              bit_pos_nxt   = 2'd0;
              code_bits_nxt = 3'd0;
            end else begin
              phase_nxt     = PH_WHITE;
              white_run_nxt = 8'd0;
              bit_pos_nxt   = bit_pos_r + 2'd1;
              code_bits_nxt = code_set;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r     <= WINDOW_SIZE_RST;
      white_min_light_r <= WHITE_MIN_LIGHT_RST;
      black_min_dark_r  <= BLACK_MIN_DARK_RST;
      in_valid_r        <= 1'b0;
      phase_r           <= PH_IDLE;
      white_run_r       <= 8'd0;
      black_run_r       <= 8'd0;
      bit_pos_r         <= 2'd0;
      code_bits_r       <= 3'd0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:     window_size_r     <= cfg_wdata;
          CFG_WHITE_MIN_LIGHT: white_min_light_r <= cfg_wdata;
          CFG_BLACK_MIN_DARK:  black_min_dark_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_beat.ready) in_valid_r <= in_beat.valid;
      phase_r     <= phase_nxt;
      white_run_r <= white_run_nxt;
      black_run_r <= black_run_nxt;
      bit_pos_r   <= bit_pos_nxt;
      code_bits_r <= code_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.ready && in_beat.valid) dark_r <= in_beat.data.dark_count;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

@@ tb/bar_width_code_reader_core_tb.sv @@
// Self-checking testbench for the bar width code reader core with a run-tracking scoreboard.
module bar_width_code_reader_core_tb;
  import bwcr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic [1:0] {READ_IDLE, READ_START, READ_WHITE, READ_BLACK} read_phase_t;
  typedef enum int {KIND_BLACK, KIND_NOT_BLACK, KIND_WHITE, KIND_NOT_WHITE} window_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [7:0] win_size;
    logic [7:0] min_light;
    logic [7:0] min_dark;
    idle_mode_t mode;
    int         windows;
    bit         long_runs;
    bit         poke_unused;
  } test_phase_t;

  class code_tracker;
    logic [7:0]  win_size;
    logic [7:0]  min_light;
    logic [7:0]  min_dark;
    read_phase_t phase;
    logic [7:0]  white_run;
    logic [7:0]  black_run;
    logic [1:0]  bit_pos;
    logic [2:0]  code_bits;
    out_data_t   pending_readings[$];
    int          mismatches;

    function new();
      win_size = WINDOW_SIZE_RST;
      min_light = WHITE_MIN_LIGHT_RST;
      min_dark = BLACK_MIN_DARK_RST;
      phase = READ_IDLE;
      white_run = '0;
      black_run = '0;
      bit_pos = '0;
      code_bits = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WINDOW_SIZE: win_size = val;
        CFG_WHITE_MIN_LIGHT: min_light = val;
        CFG_BLACK_MIN_DARK: min_dark = val;
        default: ;
      endcase
    endfunction

    function void classify(input logic [7:0] dark, output bit is_black, output bit is_white);
      logic [7:0] clipped;
      clipped = (dark > win_size) ? win_size : dark;
      is_black = clipped > min_dark;
      is_white = 8'(win_size - clipped) > min_light;
    endfunction

    function void note_window(logic [7:0] dark);
      bit        is_black;
      bit        is_white;
      out_data_t r;
      classify(dark, is_black, is_white);
      case (phase)
        READ_IDLE: begin
          if (is_black) phase = READ_START;
        end
        READ_START: begin
          if (!is_black) begin
            phase = READ_WHITE;
            white_run = '0;
          end
        end
        READ_WHITE: begin
          if (is_white) begin
            if (white_run != 8'hff) white_run = white_run + 8'd1;
          end else begin
            phase = READ_BLACK;
            black_run = '0;
          end
        end
        default: begin
          if (is_black) begin
            if (black_run != 8'hff) black_run = black_run + 8'd1;
          end else begin
            r.white_width = white_run;
            r.black_width = black_run;
            r.bit_value = black_run > white_run;
            if (r.bit_value) code_bits = code_bits | 3'(1 << (CODE_BITS - 1 - int'(bit_pos)));
            bit_pos = bit_pos + 2'd1;
            r.code_value = code_bits;
            r.code_done = int'(bit_pos) >= CODE_BITS;
            pending_readings.push_back(r);
            if (r.code_done) begin
              phase = READ_IDLE;
              bit_pos = '0;
              code_bits = '0;
            end else begin
              phase = READ_WHITE;
              white_run = '0;
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reading(out_data_t got);
      out_data_t want;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
      end else begin
        want = pending_readings.pop_front();
        compare_field("white_width", want.white_width, got.white_width);
        compare_field("black_width", want.black_width, got.black_width);
        compare_field("bit_value", 8'(want.bit_value), 8'(got.bit_value));
        compare_field("code_value", 8'(want.code_value), 8'(got.code_value));
        compare_field("code_done", 8'(want.code_done), 8'(got.code_done));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    sender_idle_pct;
  int                    recv_stall_pct;
  int                    windows_sent;
  int                    cycle_count;
  bit                    garble;
  code_tracker           tracker;
  test_phase_t           phases[8];

  bwcr_stream_if #(.payload_t(in_data_t)) win_if();
  bwcr_stream_if #(.payload_t(out_data_t)) reading_if();

  bar_width_code_reader_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_beat(win_if),
    .out_beat(reading_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    reading_if.ready <= $urandom_range(0, 99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (rst_n && reading_if.valid && reading_if.ready) tracker.check_reading(reading_if.data);
  end

  function automatic logic [7:0] pick_dark(window_kind_t kind);
    logic [7:0] v;
    bit         is_black;
    bit         is_white;
    bit         hit;
    v = 8'($urandom_range(0, 255));
    if (garble && $urandom_range(0, 9) == 0) return v;
    for (int i = 0; i < 256; i++) begin
      v = 8'($urandom_range(0, 255));
      tracker.classify(v, is_black, is_white);
      case (kind)
        KIND_BLACK: hit = is_black;
        KIND_NOT_BLACK: hit = !is_black;
        KIND_WHITE: hit = is_white;
        default: hit = !is_white;
      endcase
      if (hit) return v;
    end
    return v;
  endfunction

  task automatic send_window(input logic [7:0] dark);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      win_if.valid <= 1'b0;
      @(posedge clk);
    end
    win_if.valid <= 1'b1;
    win_if.data <= in_data_t'(dark);
    @(posedge clk);
    while (!win_if.ready) @(posedge clk);
    tracker.note_window(dark);
    windows_sent++;
  endtask

  task automatic wait_drained();
    win_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic send_code(input int long_bit);
    int white_len;
    int black_len;
    garble = (long_bit < 0) && ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(1, 3)) send_window(pick_dark(KIND_BLACK));
    send_window(pick_dark(KIND_NOT_BLACK));
    for (int b = 0; b < CODE_BITS; b++) begin
      white_len = (b == long_bit) ? $urandom_range(256, 270) : $urandom_range(0, 6);
      black_len = (b == long_bit) ? $urandom_range(256, 270) : $urandom_range(0, 6);
      repeat (white_len) send_window(pick_dark(KIND_WHITE));
      send_window(pick_dark(KIND_NOT_WHITE));
      repeat (black_len) send_window(pick_dark(KIND_BLACK));
      send_window(pick_dark(KIND_NOT_BLACK));
    end
    garble = 1'b0;
  endtask

  task automatic apply_settings(input test_phase_t ph);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx = '{CFG_WINDOW_SIZE, CFG_WHITE_MIN_LIGHT, CFG_BLACK_MIN_DARK};
    val = '{ph.win_size, ph.min_light, ph.min_dark};
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ph.poke_unused) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_UNUSED_IDX;
      cfg_wdata <= CFG_DATA_W'($urandom_range(0, 255));
      @(posedge clk);
    end
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      tracker.write_register(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    case (ph.mode)
      IDLE_SENDER: begin
        sender_idle_pct = 83;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        recv_stall_pct = 83;
      end
      IDLE_BOTH: begin
        sender_idle_pct = 36;
        recv_stall_pct = 36;
      end
      default: begin
        sender_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    logic [7:0] opening[18];
    int         start_count;
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    win_if.valid = 1'b0;
    win_if.data = '0;
    reading_if.ready = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    windows_sent = 0;
    cycle_count = 0;
    garble = 1'b0;
    phases[0] = '{8'd100, 8'd90, 8'd80, IDLE_NONE, 70, 1'b0, 1'b0};
    phases[1] = '{8'd255, 8'd100, 8'd100, IDLE_SENDER, 70, 1'b0, 1'b0};
    phases[2] = '{8'd1, 8'd0, 8'd0, IDLE_RECEIVER, 70, 1'b0, 1'b0};
    phases[3] = '{8'd200, 8'd10, 8'd10, IDLE_BOTH, 70, 1'b0, 1'b0};
    phases[4] = '{8'd0, 8'd0, 8'd0, IDLE_NONE, 30, 1'b0, 1'b1};
    phases[5] = '{8'd255, 8'd255, 8'd255, IDLE_SENDER, 30, 1'b0, 1'b0};
    phases[6] = '{8'd50, 8'd20, 8'd25, IDLE_BOTH, 560, 1'b1, 1'b0};
    phases[7] = '{8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), IDLE_RECEIVER, 70, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: black above 80 dark, white below 10 dark.
    opening = '{8'd0, 8'd255, 8'd81, 8'd80, 8'd0, 8'd9, 8'd10, 8'd255, 8'd81, 8'd50,
                8'd0, 8'd50, 8'd255, 8'd255, 8'd0, 8'd50, 8'd90, 8'd0};
    foreach (opening[i]) send_window(opening[i]);
    wait_drained();

    foreach (phases[p]) begin
      apply_settings(phases[p]);
      start_count = windows_sent;
      if (phases[p].long_runs) send_code($urandom_range(0, CODE_BITS - 1));
      while (windows_sent - start_count < phases[p].windows) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) send_window(8'($urandom_range(0, 255)));
        end else begin
          send_code(-1);
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
